// File: src/btn_dbnc_pkg.sv
// Shared constants and types for the debounced button with press-burst counting.
// No dependencies; imported by the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package btn_dbnc_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int TALLY_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 72;   // 65 payload bits padded to whole bytes
    localparam int OUT_W     = 48;   // 45 payload bits padded to whole bytes

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd2;

    localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd25;
    localparam logic [CFG_W-1:0]   WINDOW_RST   = 16'd500;
    localparam logic [TALLY_W-1:0] TALLY_MAX    = 8'd255;

    typedef struct packed {
        logic [TIME_W-1:0]  last_change_ms;
        logic [TALLY_W-1:0] burst_count;
        logic               idle_long;
        logic               held_long;
        logic               release_edge;
        logic               press_edge;
        logic               is_pressed;
    } result_t;

endpackage

`default_nettype wire

// File: src/button_debounce_multi_press_top.sv
// Top level of the debounced button with press-burst counting.
// Depends on btn_dbnc_pkg (widths, register indexes, result layout).
`timescale 1ns / 1ps
`default_nettype none

// Debounced push button with multi-press burst counting. Each input word is one
// pin sample with its millisecond timestamp and a hold threshold; each sample
// gives exactly one result word. The pin level is optionally inverted, and a new
// level is taken only once debounce_ms has passed since the last accepted change
// (all time differences wrap modulo 2^32). Each rising debounced state counts one
// press (saturating at 255); once more than multi_press_window_ms has passed since
// the last change, the count is reported in burst_count and cleared.
// Timing: a sample is captured in an input register, then processed by combinational
// logic (one 32-bit subtract, a few 32-bit compares and the tally increment) into
// the result register; one word is accepted every clock unless m_axis_tready holds
// back a waiting result. The state update for a sample lands in the same edge as its
// result, so the next sample always sees it. Configuration writes are accepted every
// cycle; write only while idle.
module button_debounce_multi_press_top
    import btn_dbnc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // sample input: [31:0] now_ms, [32] raw_level, [64:33] hold_threshold_ms, rest zero
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_W-1:0]      s_axis_tdata,
    // result output: [0] is_pressed, [1] press_edge, [2] release_edge, [3] held_long,
    // [4] idle_long, [12:5] burst_count, [44:13] last_change_ms, rest zero
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata
);

    // configuration registers
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] window_reg;
    logic             invert_reg;

    // input stage
    logic              in_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic              level_reg;
    logic [TIME_W-1:0] hold_reg;

    // button state
    logic               state_reg, state_next;
    logic [TIME_W-1:0]  change_reg, change_next;
    logic               latched_reg, latched_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    // result stage
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic              advance;
    logic              level;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since;
    logic              accept;
    logic              changed;
    logic              burst_end;
    logic [TALLY_W-1:0] tally_inc;

    // Advance the compute stage whenever the result slot is free or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            window_reg   <= WINDOW_RST;
            invert_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_WINDOW:   window_reg   <= cfg_data;
                REG_INVERT:   invert_reg   <= cfg_data[0];
                default:      ; // drop writes to unused indexes
            endcase
        end
    end

    // Input register: hold the sample until the compute stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            now_reg   <= s_axis_tdata[31:0];
            level_reg <= s_axis_tdata[32];
            hold_reg  <= s_axis_tdata[64:33];
        end
    end

    // Per-sample logic: debounce, press tally, burst end, hold flags.
    always_comb
    begin
        level   = level_reg ^ invert_reg;
        elapsed = now_reg - change_reg;
        accept  = elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_reg};
        changed = accept && (level != state_reg);

        state_next  = accept ? level : state_reg;
        change_next = changed ? now_reg : change_reg;
        // a fresh change restarts the elapsed time at zero
        since       = changed ? '0 : elapsed;

        tally_inc    = tally_reg;
        latched_next = latched_reg;
        if (state_next)
        begin
            if (!latched_reg)
            begin
                if (tally_reg != TALLY_MAX)
                begin
                    tally_inc = tally_reg + 1'b1;
                end
                latched_next = 1'b1;
            end
        end
        else
        begin
            latched_next = 1'b0;
        end

        burst_end  = since > {{(TIME_W-CFG_W){1'b0}}, window_reg};
        tally_next = burst_end ? '0 : tally_inc;

        result_next.is_pressed     = state_next;
        result_next.press_edge     = state_next && changed;
        result_next.release_edge   = !state_next && changed;
        result_next.held_long      = state_next && (since >= hold_reg);
        result_next.idle_long      = !state_next && (since >= hold_reg);
        result_next.burst_count    = burst_end ? tally_inc : '0;
        result_next.last_change_ms = change_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= 1'b0;
            change_reg    <= '0;
            latched_reg   <= 1'b0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg   <= state_next;
                change_reg  <= change_next;
                latched_reg <= latched_next;
                tally_reg   <= tally_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-$bits(result_t)){1'b0}}, result_reg};

endmodule

`default_nettype wire

// File: src/btn_dbnc_checker.sv
// Port-level checks for the debounced button top level, attached by bind.
// Depends on btn_dbnc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module btn_dbnc_checker
    import btn_dbnc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // edges agree with the debounced state and never both fire
    a_edge_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && !m_axis_tdata[0])
                       && !(m_axis_tdata[2] && m_axis_tdata[0]))
        else $error("edge flag disagrees with state");

    // hold flags follow the state
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && !m_axis_tdata[0])
                       && !(m_axis_tdata[4] && m_axis_tdata[0]))
        else $error("hold flag disagrees with state");

    // the bits above the packed result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:45] == '0)
        else $error("padding bits not zero");

endmodule

bind button_debounce_multi_press_top btn_dbnc_checker u_btn_dbnc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
